@@ sv/bdtc_pkg.sv @@
// ============================================================================
// bdtc_pkg: budgeted tile cursor shared definitions
// Types, register indexes, controller states and command/status bundles.
// ============================================================================
package bdtc_pkg;

    localparam int TILE_W   = 16;
    localparam int DIV_STEPS = TILE_W;
    localparam int CNT_W    = $clog2(DIV_STEPS);
    localparam int IDX_W    = 2;

    typedef logic [TILE_W-1:0] tile_t;
    typedef logic [TILE_W:0]   tile_ext_t;
    typedef logic [IDX_W-1:0]  cfg_idx_t;

    // Register indexes of the configuration port
    localparam cfg_idx_t CFG_BYTES_PER_TILE  = 2'd0;
    localparam cfg_idx_t CFG_MAX_BYTES       = 2'd1;
    localparam cfg_idx_t CFG_QUEUE_AVAILABLE = 2'd2;

    // Request modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_PLAN  = 1'b1;

    // Budget used when max_bytes is zero
    localparam tile_t BUDGET_DEFAULT = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHUNK,
        ST_WRITE
    } state_t;

    // Outcome of one plan, settled in the chunk stage
    typedef enum logic [2:0] {
        PC_FAIL,
        PC_IDLE_CURSOR,
        PC_OUT_OF_RANGE,
        PC_NO_QUEUE,
        PC_NO_FIT,
        PC_QUEUE
    } plan_case_t;

    typedef struct packed {
        logic load_range;
        logic div_start;
        logic div_step;
        logic chunk;
        logic write;
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } sts_t;

    typedef struct packed {
        logic  ok;
        logic  queued;
        logic  complete;
        logic  budget_limited;
        logic  overflow;
        tile_t chunk_first_tile;
        tile_t queued_tiles;
        tile_t queued_bytes;
        tile_t remaining_tiles;
        tile_t next_tile;
    } result_t;

endpackage

@@ sv/bdtc_plan_if.sv @@
// ============================================================================
// bdtc_plan_if: request channel
// Valid/ready channel that carries start and plan requests.
// ============================================================================
interface bdtc_plan_if;
    import bdtc_pkg::*;

    logic  valid;
    logic  ready;
    logic  mode;
    tile_t first_tile;
    tile_t tile_count;

    modport source (output valid, output mode, output first_tile, output tile_count,
                    input ready);
    modport sink   (input valid, input mode, input first_tile, input tile_count,
                    output ready);
endinterface

@@ sv/bdtc_result_if.sv @@
// ============================================================================
// bdtc_result_if: result channel
// Valid/ready channel that carries one plan result.
// ============================================================================
interface bdtc_result_if;
    import bdtc_pkg::*;

    logic  valid;
    logic  ready;
    logic  ok;
    logic  queued;
    logic  complete;
    logic  budget_limited;
    logic  overflow;
    tile_t chunk_first_tile;
    tile_t queued_tiles;
    tile_t queued_bytes;
    tile_t remaining_tiles;
    tile_t next_tile;

    modport source (output valid, output ok, output queued, output complete,
                    output budget_limited, output overflow, output chunk_first_tile,
                    output queued_tiles, output queued_bytes, output remaining_tiles,
                    output next_tile, input ready);
    modport sink   (input valid, input ok, input queued, input complete,
                    input budget_limited, input overflow, input chunk_first_tile,
                    input queued_tiles, input queued_bytes, input remaining_tiles,
                    input next_tile, output ready);
endinterface

@@ sv/bdtc_dp.sv @@
// ============================================================================
// bdtc_dp: budgeted tile cursor datapath
// Configuration and cursor registers, bit-serial budget divider, chunk
// selection and the result register.
// ============================================================================
module bdtc_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  bdtc_pkg::cfg_idx_t cfg_index,
    input  bdtc_pkg::tile_t    cfg_data,
    input  bdtc_pkg::tile_t    first_tile,
    input  bdtc_pkg::tile_t    tile_count,
    input  bdtc_pkg::cmd_t     cmd,
    output bdtc_pkg::sts_t     sts,
    output bdtc_pkg::result_t  result
);
    import bdtc_pkg::*;

    // configuration
    tile_t bpt_reg;
    tile_t max_bytes_reg;
    logic  qavail_reg;

    // cursor state
    tile_t start_reg, start_next;
    tile_t len_reg, len_next;
    tile_t pos_reg, pos_next;
    logic  active_reg, active_next;

    // divider
    tile_t            rem_reg, rem_next;
    tile_t            quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    tile_ext_t        end_reg;

    // chunk stage
    plan_case_t pcase_reg, pcase_next;
    tile_t      qtiles_reg, qtiles_next;
    tile_t      remain_reg, remain_next;
    logic       blim_reg, blim_next;

    result_t result_reg, result_next;

    tile_t     budget;
    tile_ext_t shifted;
    logic [TILE_W+1:0] trial;
    tile_ext_t end_calc;
    tile_ext_t remain_ext;
    logic      out_range;
    tile_ext_t pos_sum;
    tile_t     pos_adv;
    tile_ext_t remain_after;
    logic [2*TILE_W-1:0] product;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpt_reg       <= '0;
            max_bytes_reg <= '0;
            qavail_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BYTES_PER_TILE:  bpt_reg       <= cfg_data;
                CFG_MAX_BYTES:       max_bytes_reg <= cfg_data;
                CFG_QUEUE_AVAILABLE: qavail_reg    <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Divider: restoring, one quotient bit per step
    assign budget  = (max_bytes_reg != '0) ? max_bytes_reg : BUDGET_DEFAULT;
    assign shifted = {rem_reg, quo_reg[TILE_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, bpt_reg};
    assign end_calc = {1'b0, start_reg} + {1'b0, len_reg};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (cmd.div_start)
        begin
            rem_next = '0;
            quo_next = budget;
            cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            if (!trial[TILE_W+1])
            begin
                rem_next = trial[TILE_W-1:0];
                quo_next = {quo_reg[TILE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[TILE_W-1:0];
                quo_next = {quo_reg[TILE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign sts.div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (cmd.div_start)
        begin
            end_reg <= end_calc;
        end
    end

    // Chunk stage: classify the plan and size the chunk
    assign out_range  = ({1'b0, pos_reg} < {1'b0, start_reg}) || ({1'b0, pos_reg} >= end_reg);
    assign remain_ext = end_reg - {1'b0, pos_reg};

    always_comb
    begin
        pcase_next  = PC_QUEUE;
        remain_next = remain_ext[TILE_W-1:0];
        qtiles_next = (remain_next < quo_reg) ? remain_next : quo_reg;
        blim_next   = (qtiles_next < remain_next);
        if (bpt_reg == '0)
        begin
            pcase_next = PC_FAIL;
        end
        else if (!active_reg || len_reg == '0)
        begin
            pcase_next = PC_IDLE_CURSOR;
        end
        else if (out_range)
        begin
            pcase_next = PC_OUT_OF_RANGE;
        end
        else if (!qavail_reg)
        begin
            pcase_next = PC_NO_QUEUE;
        end
        else if (quo_reg == '0)
        begin
            pcase_next = PC_NO_FIT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.chunk)
        begin
            pcase_reg  <= pcase_next;
            qtiles_reg <= qtiles_next;
            remain_reg <= remain_next;
            blim_reg   <= blim_next;
        end
    end

    // Write stage: advance the cursor and form the result
    assign product      = qtiles_reg * bpt_reg;
    assign pos_sum      = {1'b0, pos_reg} + {1'b0, qtiles_reg};
    assign pos_adv      = pos_sum[TILE_W-1:0];
    assign remain_after = end_reg - {1'b0, pos_adv};

    always_comb
    begin
        start_next  = start_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        active_next = active_reg;
        result_next = result_reg;

        if (cmd.load_range)
        begin
            start_next  = (tile_count != '0) ? first_tile : '0;
            len_next    = tile_count;
            pos_next    = start_next;
            active_next = (tile_count != '0);
        end

        if (cmd.write)
        begin
            result_next = '0;
            unique case (pcase_reg)
                PC_FAIL:
                begin
                    result_next = '0;
                end
                PC_IDLE_CURSOR:
                begin
                    result_next.ok        = 1'b1;
                    result_next.complete  = 1'b1;
                    result_next.next_tile = pos_reg;
                end
                PC_OUT_OF_RANGE:
                begin
                    pos_next              = end_reg[TILE_W-1:0];
                    active_next           = 1'b0;
                    result_next.ok        = 1'b1;
                    result_next.complete  = 1'b1;
                    result_next.next_tile = end_reg[TILE_W-1:0];
                end
                PC_NO_QUEUE:
                begin
                    result_next.overflow        = 1'b1;
                    result_next.remaining_tiles = remain_reg;
                    result_next.next_tile       = pos_reg;
                end
                PC_NO_FIT:
                begin
                    result_next.budget_limited  = 1'b1;
                    result_next.remaining_tiles = remain_reg;
                    result_next.next_tile       = pos_reg;
                end
                PC_QUEUE:
                begin
                    pos_next    = pos_adv;
                    active_next = (remain_after != '0);
                    result_next.ok               = 1'b1;
                    result_next.queued           = 1'b1;
                    result_next.complete         = (remain_after == '0);
                    result_next.budget_limited   = blim_reg;
                    result_next.chunk_first_tile = pos_reg;
                    result_next.queued_tiles     = qtiles_reg;
                    result_next.queued_bytes     = product[TILE_W-1:0];
                    result_next.remaining_tiles  = remain_after[TILE_W-1:0];
                    result_next.next_tile        = pos_adv;
                end
                default:
                begin
                    result_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            len_reg    <= '0;
            pos_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            start_reg  <= start_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

@@ sv/bdtc_ctrl.sv @@
// ============================================================================
// bdtc_ctrl: budgeted tile cursor controller
// Loads start requests and sequences each plan through divide, chunk and write; owns the result valid.
// ============================================================================
module bdtc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_mode,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  bdtc_pkg::sts_t sts,
    output bdtc_pkg::cmd_t cmd
);
    import bdtc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_mode == MODE_PLAN)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_CHUNK;
                end
            end
            ST_CHUNK:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.load_range = in_valid && in_mode == MODE_START;
                cmd.div_start  = in_valid && in_mode == MODE_PLAN;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_CHUNK:
            begin
                cmd.chunk = 1'b1;
            end
            ST_WRITE:
            begin
                cmd.write = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid_next = cmd.write ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // never overwrite a result still waiting on the sink
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while pending");

    // a result appears only after a write
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.write))
        else $error("result valid without write");

    // a divide runs to its last step before the chunk stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE && sts.div_last) |=> (state_reg == ST_CHUNK))
        else $error("divide did not hand off to chunk stage");

    // a plan request starts the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == ST_DIVIDE && !in_ready))
        else $error("plan did not enter divide");

endmodule

@@ sv/budgeted_tile_cursor_top.sv @@
// ============================================================================
// budgeted_tile_cursor_top: budgeted tile cursor
// Walks a tile range one chunk per frame within a byte budget.
// ============================================================================
// A start request (mode 0) loads the tile range in the cycle it is accepted
// and gives no result, so start requests can be taken every cycle. A plan
// request (mode 1) gives one result; no further request is accepted until
// it has loaded the divider, run the bit-serial divide of the byte budget by
// the tile cost (one quotient bit per cycle), sized the chunk and written the
// result register. The result register holds a finished result until the
// sink takes it; a plan that finishes while the previous result still waits
// holds in its write stage. Configuration writes take effect at the clock
// edge where cfg_we is high and are expected only while no request is in
// flight.
// ============================================================================
module budgeted_tile_cursor_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  bdtc_pkg::cfg_idx_t cfg_index,
    input  bdtc_pkg::tile_t    cfg_data,
    bdtc_plan_if.sink          plan,
    bdtc_result_if.source      result
);
    import bdtc_pkg::*;

    cmd_t    cmd;
    sts_t    sts;
    result_t res;

    // sequence each request
    bdtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (plan.valid),
        .in_mode   (plan.mode),
        .in_ready  (plan.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // hold cursor state, divide the budget, build the result
    bdtc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .first_tile (plan.first_tile),
        .tile_count (plan.tile_count),
        .cmd        (cmd),
        .sts        (sts),
        .result     (res)
    );

    // drive the result channel payload
    assign result.ok               = res.ok;
    assign result.queued           = res.queued;
    assign result.complete         = res.complete;
    assign result.budget_limited   = res.budget_limited;
    assign result.overflow         = res.overflow;
    assign result.chunk_first_tile = res.chunk_first_tile;
    assign result.queued_tiles     = res.queued_tiles;
    assign result.queued_bytes     = res.queued_bytes;
    assign result.remaining_tiles  = res.remaining_tiles;
    assign result.next_tile        = res.next_tile;

endmodule
